// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the source text tokenizer.
// Depends on nothing; each use needs signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/stt_pkg.sv =====
// Shared types, constants and character classes for the source text tokenizer.
// Depends on nothing; used by stt_scan, stt_rsp_fifo and the top level.
package stt_pkg;

   localparam int PosBitsDefault = 24;

   // Result queue geometry
   localparam int FifoDepth    = 4;
   localparam int FifoAddrBits = $clog2(FifoDepth);
   localparam int FifoCntBits  = $clog2(FifoDepth + 1);
   localparam logic [FifoCntBits-1:0] FifoRoomMax = FifoCntBits'(FifoDepth - 2);
   localparam logic [FifoCntBits-1:0] FifoCntMax  = FifoCntBits'(FifoDepth);

   // Token kinds
   localparam logic [1:0] KindWord   = 2'd0;
   localparam logic [1:0] KindSingle = 2'd1;
   localparam logic [1:0] KindPair   = 2'd2;
   localparam logic [1:0] KindString = 2'd3;

   // Character codes with a role of their own
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharHash    = 8'h23;
   localparam logic [7:0] CharColon   = 8'h3A;
   localparam logic [7:0] CharEqual   = 8'h3D;
   localparam logic [7:0] CharBslash  = 8'h5C;
   localparam logic [7:0] CharDquote  = 8'h22;
   localparam logic [7:0] CharSquote  = 8'h27;

   localparam logic [23:0] Field24Max = 24'hFF_FFFF;

   // One result record
   typedef struct packed {
      logic [1:0]  token_kind;
      logic [23:0] start_pos;
      logic [23:0] token_len;
      logic [23:0] line_number;
      logic [23:0] column;
      logic [7:0]  first_char;
      logic        last_of_run;
   } stt_token_type;

   // Records produced by one request, in order
   typedef struct packed {
      logic [1:0]    count;
      stt_token_type tok0;
      stt_token_type tok1;
   } stt_push_type;

   // Queue status seen by the input side
   typedef struct packed {
      logic                   room;
      logic [FifoCntBits-1:0] fill;
   } stt_fifo_status_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
             (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
   endfunction

   // . $ , < > ( ) ! [ ] / + * : = #
   function automatic logic is_special(input logic [7:0] c);
      return (c == 8'h2E) || (c == 8'h24) || (c == 8'h2C) || (c == 8'h3C) ||
             (c == 8'h3E) || (c == 8'h28) || (c == 8'h29) || (c == 8'h21) ||
             (c == 8'h5B) || (c == 8'h5D) || (c == 8'h2F) || (c == 8'h2B) ||
             (c == 8'h2A) || (c == CharColon) || (c == CharEqual) ||
             (c == CharHash);
   endfunction

endpackage

// ===== hw/rtl/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer: input register, scanner, result queue.
// Depends on stt_pkg, stt_scan, stt_rsp_fifo and assert_macros.svh.
//
// Takes one byte of source text per request and returns token records on the
// rsp_ side. A byte is held in the input register after acceptance, consumed
// while the queue has room, and yields zero, one or two records; with the result
// queue empty, the first record of a byte passes the input register and a
// queue entry before it is offered on rsp_. The input side sustains one byte
// per cycle as long as records are taken as fast as they are made; a byte that
// yields two records adds one record of output work, absorbed by a four-entry
// result queue, and req_stall rises only while the queue holds more than two
// records. Asserting req_end_of_text with the last byte flushes any open token
// and returns all position, line and column counters to their start values.
`include "assert_macros.svh"

module source_text_tokenizer_top #(
   parameter int POS_BITS = stt_pkg::PosBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_token_kind,
   output logic [23:0] rsp_start_pos,
   output logic [23:0] rsp_token_len,
   output logic [23:0] rsp_line_number,
   output logic [23:0] rsp_column,
   output logic [7:0]  rsp_first_char,
   output logic        rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       eot_ff;
   logic       accept;
   logic       advance;
   logic       rsp_take;

   stt_pkg::stt_push_type        push;
   stt_pkg::stt_token_type       head;
   stt_pkg::stt_fifo_status_type fifo_status;

   assign advance     = in_valid_ff && fifo_status.room;
   assign req_stall   = in_valid_ff && !fifo_status.room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_take    = rsp_valid && !rsp_stall;

   // Hold the accepted request until the scanner consumes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_code;
         eot_ff  <= req_end_of_text;
      end
   end

   stt_scan #(
      .POS_BITS (POS_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .char_code   (char_ff),
      .end_of_text (eot_ff),
      .push        (push)
   );

   stt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (!rsp_stall),
      .head       (head),
      .head_valid (rsp_valid),
      .status     (fifo_status)
   );

   // Drive the response fields from the queue head
   assign rsp_token_kind  = head.token_kind;
   assign rsp_start_pos   = head.start_pos;
   assign rsp_token_len   = head.token_len;
   assign rsp_line_number = head.line_number;
   assign rsp_column      = head.column;
   assign rsp_first_char  = head.first_char;
   assign rsp_last_of_run = head.last_of_run;

   `ASSERT_ALWAYS(a_fifo_no_overflow, fifo_status.fill <= stt_pkg::FifoCntMax, "queue overflow")
   `ASSERT_ALWAYS(a_push_at_most_two, push.count != 2'd3, "over two records per request")
   `ASSERT_IMPLIES(a_rsp_drops_after_pop, $fell(rsp_valid), $past(rsp_take), "response withdrawn")

endmodule

// ===== hw/rtl/stt_scan.sv =====
// Scanner state and per-byte token logic of the source text tokenizer.
// Depends on stt_pkg; feeds stt_rsp_fifo with up to two records per request.
module stt_scan #(
   parameter int POS_BITS = stt_pkg::PosBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          char_code,
   input  logic                end_of_text,
   output stt_pkg::stt_push_type push
);

   typedef enum logic [3:0] {
      ModeIdle, ModeWord, ModeColon, ModeEq, ModeHash, ModeLine,
      ModeBlock, ModeBlockHash, ModeStr, ModeStrEsc
   } mode_type;

   localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);

   mode_type            mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] line_start_ff, line_start_in;
   logic [POS_BITS-1:0] tok_start_ff, tok_start_in;
   logic [23:0]         line_cnt_ff, line_cnt_in;
   logic [7:0]          first_ff, first_in;
   logic                quote_single_ff, quote_single_in;

   // Raw tokens: closing token, immediate single special, end-of-text flush
   logic                v0, v1, v2;
   logic [1:0]          k0, k1, k2;
   logic [POS_BITS-1:0] s0, s1, s2, e0, e1, e2;
   logic [7:0]          f0, f1, f2;

   logic                idle_go, str_go, newline;
   logic [POS_BITS-1:0] pos_inc;
   logic [7:0]          pair_char, close_quote;

   logic [1:0]          sel_k0, sel_k1;
   logic [POS_BITS-1:0] sel_s0, sel_s1, sel_e0, sel_e1;
   logic [7:0]          sel_f0, sel_f1;
   logic [1:0]          n_tok;

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      return (v == PosMax) ? v : v + PosOne;
   endfunction

   // Turn start/end into a result record with length and column
   function automatic stt_pkg::stt_token_type make_rec(
      input logic [1:0]          kind,
      input logic [POS_BITS-1:0] s,
      input logic [POS_BITS-1:0] e,
      input logic [7:0]          f,
      input logic [POS_BITS-1:0] ls,
      input logic [23:0]         lc
   );
      logic [POS_BITS-1:0]   diff;
      logic [POS_BITS-1:0]   cdiff;
      logic [31:0]           len32;
      logic [31:0]           start32;
      logic [31:0]           col32;
      stt_pkg::stt_token_type r;
      diff    = (e > s) ? (e - s) : PosOne;
      cdiff   = (s >= ls) ? (s - ls) : '0;
      len32   = 32'(diff);
      start32 = 32'(s);
      col32   = 32'(cdiff);
      r.token_kind  = kind;
      r.start_pos   = start32[23:0];
      r.token_len   = (len32 > 32'(stt_pkg::Field24Max)) ? stt_pkg::Field24Max
                                                          : len32[23:0];
      r.line_number = lc;
      r.column      = col32[23:0];
      r.first_char  = f;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   assign pos_inc     = sat_inc(pos_ff);
   assign pair_char   = (mode_ff == ModeColon) ? stt_pkg::CharColon : stt_pkg::CharEqual;
   assign close_quote = quote_single_ff ? stt_pkg::CharSquote : stt_pkg::CharDquote;

   // Next state and raw tokens for the byte in the input register
   always_comb begin
      mode_in         = mode_ff;
      pos_in          = pos_ff;
      line_start_in   = line_start_ff;
      tok_start_in    = tok_start_ff;
      line_cnt_in     = line_cnt_ff;
      first_in        = first_ff;
      quote_single_in = quote_single_ff;
      idle_go = 1'b0;
      str_go  = 1'b0;
      newline = 1'b0;
      v0 = 1'b0; k0 = stt_pkg::KindWord; s0 = tok_start_ff; e0 = pos_ff; f0 = first_ff;
      v1 = 1'b0; k1 = stt_pkg::KindSingle; s1 = pos_ff; e1 = pos_inc; f1 = char_code;
      v2 = 1'b0; k2 = stt_pkg::KindWord; s2 = pos_ff; e2 = pos_inc; f2 = first_ff;

      case (mode_ff)
         ModeWord: begin
            if (stt_pkg::is_space(char_code) || stt_pkg::is_special(char_code)) begin
               v0 = 1'b1;
               k0 = stt_pkg::KindWord;
               idle_go = 1'b1;
            end
         end
         ModeColon, ModeEq: begin
            v0 = 1'b1;
            f0 = pair_char;
            if (char_code == pair_char) begin
               k0 = stt_pkg::KindPair;
               e0 = pos_inc;
               mode_in = ModeIdle;
            end else begin
               k0 = stt_pkg::KindSingle;
               e0 = sat_inc(tok_start_ff);
               idle_go = 1'b1;
            end
         end
         ModeHash: begin
            if (char_code == stt_pkg::CharHash) begin
               mode_in = ModeBlock;
            end else if (char_code == stt_pkg::CharNewline) begin
               newline = 1'b1;
               mode_in = ModeIdle;
            end else begin
               mode_in = ModeLine;
            end
         end
         ModeLine: begin
            if (char_code == stt_pkg::CharNewline) begin
               newline = 1'b1;
               mode_in = ModeIdle;
            end
         end
         ModeBlock, ModeBlockHash: begin
            if (char_code == stt_pkg::CharHash) begin
               mode_in = (mode_ff == ModeBlockHash) ? ModeIdle : ModeBlockHash;
            end else begin
               newline = (char_code == stt_pkg::CharNewline);
               mode_in = ModeBlock;
            end
         end
         ModeStr: begin
            str_go = 1'b1;
         end
         ModeStrEsc: begin
            if (char_code == close_quote) begin
               mode_in = ModeStr;
            end else begin
               str_go = 1'b1;
            end
         end
         default: begin
            idle_go = 1'b1;
         end
      endcase

      // Advance inside a string: close on the matching quote
      if (str_go) begin
         if (char_code == close_quote) begin
            v0 = 1'b1;
            k0 = stt_pkg::KindString;
            e0 = pos_inc;
            mode_in = ModeIdle;
         end else if (char_code == stt_pkg::CharBslash) begin
            mode_in = ModeStrEsc;
         end else begin
            mode_in = ModeStr;
         end
      end

      // Open a new token, or skip whitespace between tokens
      if (idle_go) begin
         if (stt_pkg::is_space(char_code)) begin
            newline = (char_code == stt_pkg::CharNewline);
            mode_in = ModeIdle;
         end else begin
            tok_start_in = pos_ff;
            first_in     = char_code;
            if (char_code == stt_pkg::CharHash) begin
               mode_in = ModeHash;
            end else if (char_code == stt_pkg::CharColon) begin
               mode_in = ModeColon;
            end else if (char_code == stt_pkg::CharEqual) begin
               mode_in = ModeEq;
            end else if (stt_pkg::is_special(char_code)) begin
               v1 = 1'b1;
               mode_in = ModeIdle;
            end else if ((char_code == stt_pkg::CharDquote) ||
                         (char_code == stt_pkg::CharSquote)) begin
               quote_single_in = (char_code == stt_pkg::CharSquote);
               mode_in = ModeStr;
            end else begin
               mode_in = ModeWord;
            end
         end
      end

      // Count lines outside strings and move the line start
      if (newline) begin
         line_cnt_in   = (line_cnt_ff == stt_pkg::Field24Max) ? line_cnt_ff
                                                                : line_cnt_ff + 24'd1;
         line_start_in = pos_inc;
      end

      // Flush the open token on the last byte, then return to reset state
      if (end_of_text) begin
         s2 = tok_start_in;
         f2 = first_in;
         case (mode_in)
            ModeWord: begin
               v2 = 1'b1;
               k2 = stt_pkg::KindWord;
            end
            ModeColon, ModeEq: begin
               v2 = 1'b1;
               k2 = stt_pkg::KindSingle;
               e2 = sat_inc(tok_start_in);
            end
            ModeStr, ModeStrEsc: begin
               v2 = 1'b1;
               k2 = stt_pkg::KindString;
            end
            default: begin
               v2 = 1'b0;
            end
         endcase
         mode_in         = ModeIdle;
         pos_in          = '0;
         line_cnt_in     = 24'd1;
         line_start_in   = '0;
         tok_start_in    = '0;
         first_in        = 8'd0;
         quote_single_in = 1'b0;
      end else begin
         pos_in = pos_inc;
      end
   end

   // Pack the valid raw tokens into two ordered slots
   always_comb begin
      if (v0) begin
         sel_k0 = k0; sel_s0 = s0; sel_e0 = e0; sel_f0 = f0;
      end else if (v1) begin
         sel_k0 = k1; sel_s0 = s1; sel_e0 = e1; sel_f0 = f1;
      end else begin
         sel_k0 = k2; sel_s0 = s2; sel_e0 = e2; sel_f0 = f2;
      end
      if (v0 && v1) begin
         sel_k1 = k1; sel_s1 = s1; sel_e1 = e1; sel_f1 = f1;
      end else begin
         sel_k1 = k2; sel_s1 = s2; sel_e1 = e2; sel_f1 = f2;
      end
   end

   assign n_tok = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};

   // Build the records against the line state before this byte
   always_comb begin
      push.count = advance ? n_tok : 2'd0;
      push.tok0  = make_rec(sel_k0, sel_s0, sel_e0, sel_f0, line_start_ff, line_cnt_ff);
      push.tok1  = make_rec(sel_k1, sel_s1, sel_e1, sel_f1, line_start_ff, line_cnt_ff);
      push.tok0.last_of_run = (n_tok == 2'd1);
      push.tok1.last_of_run = 1'b1;
   end

   // Hold scanner state; update once per consumed request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= ModeIdle;
         pos_ff          <= '0;
         line_start_ff   <= '0;
         tok_start_ff    <= '0;
         line_cnt_ff     <= 24'd1;
         first_ff        <= 8'd0;
         quote_single_ff <= 1'b0;
      end else if (advance) begin
         mode_ff         <= mode_in;
         pos_ff          <= pos_in;
         line_start_ff   <= line_start_in;
         tok_start_ff    <= tok_start_in;
         line_cnt_ff     <= line_cnt_in;
         first_ff        <= first_in;
         quote_single_ff <= quote_single_in;
      end
   end

endmodule

// ===== hw/rtl/stt_rsp_fifo.sv =====
// Result queue of the source text tokenizer: takes up to two records a cycle,
// delivers one a cycle on the rsp_ side while pop is high. Depends on stt_pkg.
module stt_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  stt_pkg::stt_push_type        push,
   input  logic                         pop,
   output stt_pkg::stt_token_type       head,
   output logic                         head_valid,
   output stt_pkg::stt_fifo_status_type status
);

   stt_pkg::stt_token_type entry_ff [stt_pkg::FifoDepth];

   logic [stt_pkg::FifoAddrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::FifoAddrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stt_pkg::FifoCntBits-1:0]  count_ff, count_in;
   logic [stt_pkg::FifoAddrBits-1:0] wr_ptr_next;
   logic                             pop_go;

   assign pop_go      = pop && (count_ff != '0);
   assign wr_ptr_next = wr_ptr_ff + stt_pkg::FifoAddrBits'(1);
   assign wr_ptr_in   = wr_ptr_ff + stt_pkg::FifoAddrBits'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + stt_pkg::FifoAddrBits'(pop_go);
   assign count_in    = count_ff + stt_pkg::FifoCntBits'(push.count)
                                 - stt_pkg::FifoCntBits'(pop_go);

   assign head        = entry_ff[rd_ptr_ff];
   assign head_valid  = (count_ff != '0);
   assign status.room = (count_ff <= stt_pkg::FifoRoomMax);
   assign status.fill = count_ff;

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming records in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.tok1;
      end
   end

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the source text tokenizer: byte stream in, token records out.
// Depends on stt_pkg and source_text_tokenizer_top; the token predictor lives in token_ledger.
`timescale 1ns / 1ps

module testbench;

   localparam int    ByteTarget = 1050;
   localparam string PunctSet   = ".$,<>()![]/+*:=#";

   typedef enum bit [3:0] {
      ModeIdle, ModeWord, ModeColon, ModeEqual, ModeHash, ModeLineNote,
      ModeBlockNote, ModeBlockHash, ModeQuoted, ModeEscape
   } scan_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_token_kind;
   logic [23:0] rsp_start_pos;
   logic [23:0] rsp_token_len;
   logic [23:0] rsp_line_number;
   logic [23:0] rsp_column;
   logic [7:0]  rsp_first_char;
   logic        rsp_last_of_run;

   int          sent_bytes = 0;
   int unsigned stall_hold = 0;

   source_text_tokenizer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_token_len   (rsp_token_len),
      .rsp_line_number (rsp_line_number),
      .rsp_column      (rsp_column),
      .rsp_first_char  (rsp_first_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // character classes
   function automatic bit is_blank(input bit [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_punct(input bit [7:0] c);
      for (int i = 0; i < PunctSet.len(); i++) begin
         if (PunctSet[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Predict token records per accepted byte and match them against the block's output
   class token_ledger;
      scan_mode_type          mode;
      bit [23:0]              pos;
      bit [23:0]              line_no;
      bit [23:0]              line_base;
      bit [23:0]              tok_start;
      bit [7:0]               tok_first;
      bit                     single_quote;
      bit                     failed;
      stt_pkg::stt_token_type pending_tokens[$];
      stt_pkg::stt_token_type step_tokens[$];

      function new();
         failed = 1'b0;
         restart();
      endfunction

      function void restart();
         mode         = ModeIdle;
         pos          = '0;
         line_no      = 24'd1;
         line_base    = '0;
         tok_start    = '0;
         tok_first    = '0;
         single_quote = 1'b0;
      endfunction

      function int outstanding();
         return pending_tokens.size();
      endfunction

      // saturating increment for positions and lines
      function bit [23:0] bump(input bit [23:0] v);
         return (v == stt_pkg::Field24Max) ? v : v + 24'd1;
      endfunction

      function void new_line(input bit [23:0] p);
         line_no   = bump(line_no);
         line_base = bump(p);
      endfunction

      function void add_token(input bit [1:0] kind, input bit [23:0] s, input bit [23:0] e,
                              input bit [7:0] first);
         stt_pkg::stt_token_type t;
         if (step_tokens.size() >= 2) return;
         t.token_kind  = kind;
         t.start_pos   = s;
         t.token_len   = (e > s) ? e - s : 24'd1;
         t.line_number = line_no;
         t.column      = (s >= line_base) ? s - line_base : 24'd0;
         t.first_char  = first;
         t.last_of_run = 1'b0;
         step_tokens.push_back(t);
      endfunction

      // byte seen between tokens
      function void open_byte(input bit [7:0] c, input bit [23:0] p);
         if (is_blank(c)) begin
            if (c == stt_pkg::CharNewline) new_line(p);
            mode = ModeIdle;
            return;
         end
         tok_start = p;
         tok_first = c;
         if (c == stt_pkg::CharHash) mode = ModeHash;
         else if (c == stt_pkg::CharColon) mode = ModeColon;
         else if (c == stt_pkg::CharEqual) mode = ModeEqual;
         else if (is_punct(c)) begin
            add_token(stt_pkg::KindSingle, p, bump(p), c);
            mode = ModeIdle;
         end else if (c == stt_pkg::CharDquote || c == stt_pkg::CharSquote) begin
            single_quote = (c == stt_pkg::CharSquote);
            mode = ModeQuoted;
         end else mode = ModeWord;
      endfunction

      function void quoted_byte(input bit [7:0] c, input bit [23:0] p, input bit [7:0] q);
         if (c == q) begin
            add_token(stt_pkg::KindString, tok_start, bump(p), tok_first);
            mode = ModeIdle;
         end else if (c == stt_pkg::CharBslash) mode = ModeEscape;
         else mode = ModeQuoted;
      endfunction

      // advance the scanner by one accepted request and queue its records
      function void take_byte(input bit [7:0] c, input bit eot);
         bit [23:0] p;
         bit [7:0]  q;
         bit [7:0]  pc;
         p = pos;
         q = single_quote ? stt_pkg::CharSquote : stt_pkg::CharDquote;
         step_tokens.delete();
         case (mode)
            ModeWord: begin
               if (is_blank(c) || is_punct(c)) begin
                  add_token(stt_pkg::KindWord, tok_start, p, tok_first);
                  open_byte(c, p);
               end
            end
            ModeColon, ModeEqual: begin
               pc = (mode == ModeColon) ? stt_pkg::CharColon : stt_pkg::CharEqual;
               if (c == pc) begin
                  add_token(stt_pkg::KindPair, tok_start, bump(p), pc);
                  mode = ModeIdle;
               end else begin
                  add_token(stt_pkg::KindSingle, tok_start, bump(tok_start), pc);
                  open_byte(c, p);
               end
            end
            ModeHash: begin
               if (c == stt_pkg::CharHash) mode = ModeBlockNote;
               else if (c == stt_pkg::CharNewline) begin
                  new_line(p);
                  mode = ModeIdle;
               end else mode = ModeLineNote;
            end
            ModeLineNote: begin
               if (c == stt_pkg::CharNewline) begin
                  new_line(p);
                  mode = ModeIdle;
               end
            end
            ModeBlockNote, ModeBlockHash: begin
               if (c == stt_pkg::CharHash) begin
                  mode = (mode == ModeBlockHash) ? ModeIdle : ModeBlockHash;
               end else begin
                  if (c == stt_pkg::CharNewline) new_line(p);
                  mode = ModeBlockNote;
               end
            end
            ModeQuoted: quoted_byte(c, p, q);
            ModeEscape: begin
               if (c == q) mode = ModeQuoted;
               else quoted_byte(c, p, q);
            end
            default: open_byte(c, p);
         endcase

         // flush any open token at end of text, then start over
         if (eot) begin
            case (mode)
               ModeWord: add_token(stt_pkg::KindWord, tok_start, bump(p), tok_first);
               ModeColon, ModeEqual:
                  add_token(stt_pkg::KindSingle, tok_start, bump(tok_start), tok_first);
               ModeQuoted, ModeEscape:
                  add_token(stt_pkg::KindString, tok_start, bump(p), tok_first);
               default: ;
            endcase
            restart();
         end else pos = bump(p);

         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      endfunction

      function void compare_field(input string name, input bit [23:0] want,
                                  input bit [23:0] got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            failed = 1'b1;
         end
      endfunction

      // match one output record against the oldest expected one
      function void match_token(input stt_pkg::stt_token_type got);
         stt_pkg::stt_token_type want;
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none actual kind %0d start %0d",
                     $time, got.token_kind, got.start_pos);
            failed = 1'b1;
            return;
         end
         want = pending_tokens.pop_front();
         compare_field("token_kind", want.token_kind, got.token_kind);
         compare_field("start_pos", want.start_pos, got.start_pos);
         compare_field("token_len", want.token_len, got.token_len);
         compare_field("line_number", want.line_number, got.line_number);
         compare_field("column", want.column, got.column);
         compare_field("first_char", want.first_char, got.first_char);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction
   endclass

   token_ledger ledger;

   always #1 clock = ~clock;

   // mostly short waits, now and then a long one
   function automatic int unsigned pick_wait();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [7:0] pick_word_byte();
      bit [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (is_blank(b) || is_punct(b) || b == stt_pkg::CharDquote ||
             b == stt_pkg::CharSquote);
      return b;
   endfunction

   function automatic bit [7:0] pick_blank();
      bit [7:0] b;
      do b = 8'($urandom_range(8'h09, 8'h20));
      while (!is_blank(b));
      return b;
   endfunction

   // drive one request and hold it until accepted
   task automatic send_byte(input bit [7:0] code, input bit last, input bit calm);
      int unsigned gap;
      gap = calm ? 0 : pick_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= code;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall);
      ledger.take_byte(code, last);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic send_text(input bit [7:0] text[$], input bit close, input bit early);
      bit calm;
      bit last;
      calm = ($urandom_range(0, 3) == 0);
      foreach (text[i]) begin
         last = (close && i == text.size() - 1) || (early && $urandom_range(0, 49) == 0);
         send_byte(text[i], last, calm);
      end
   endtask

   // append one lexical piece, mostly well formed, sometimes noise
   task automatic add_piece(ref bit [7:0] text[$]);
      int unsigned kind;
      int unsigned n;
      bit [7:0]    quote;
      bit [7:0]    b;
      kind = $urandom_range(0, 19);
      if (kind < 5) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         repeat (n) text.push_back(pick_word_byte());
      end else if (kind < 8) begin
         text.push_back(PunctSet[$urandom_range(0, 15)]);
      end else if (kind < 9) begin
         b = $urandom_range(0, 1) ? stt_pkg::CharColon : stt_pkg::CharEqual;
         text.push_back(b);
         text.push_back(b);
      end else if (kind < 12) begin
         quote = $urandom_range(0, 1) ? stt_pkg::CharSquote : stt_pkg::CharDquote;
         text.push_back(quote);
         n = $urandom_range(0, 8);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0: begin
                  text.push_back(stt_pkg::CharBslash);
                  text.push_back(quote);
               end
               1: begin
                  text.push_back(stt_pkg::CharBslash);
                  text.push_back(pick_word_byte());
               end
               2: text.push_back(stt_pkg::CharNewline);
               3: text.push_back(quote == stt_pkg::CharSquote ? stt_pkg::CharDquote
                                                              : stt_pkg::CharSquote);
               default: begin
                  do b = 8'($urandom_range(0, 255));
                  while (b == quote || b == stt_pkg::CharBslash);
                  text.push_back(b);
               end
            endcase
         end
         // leave some strings open
         if ($urandom_range(0, 9) != 0) text.push_back(quote);
      end else if (kind < 16) begin
         n = $urandom_range(1, 3);
         repeat (n) text.push_back(pick_blank());
      end else if (kind < 17) begin
         text.push_back(stt_pkg::CharHash);
         n = $urandom_range(0, 8);
         repeat (n) begin
            do b = 8'($urandom_range(0, 255));
            while (b == stt_pkg::CharNewline || b == stt_pkg::CharHash);
            text.push_back(b);
         end
         text.push_back(stt_pkg::CharNewline);
      end else if (kind < 18) begin
         text.push_back(stt_pkg::CharHash);
         text.push_back(stt_pkg::CharHash);
         n = $urandom_range(0, 10);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0: begin
                  text.push_back(stt_pkg::CharHash);
                  text.push_back(pick_word_byte());
               end
               1: text.push_back(stt_pkg::CharNewline);
               default: begin
                  do b = 8'($urandom_range(0, 255)); while (b == stt_pkg::CharHash);
                  text.push_back(b);
               end
            endcase
         end
         text.push_back(stt_pkg::CharHash);
         text.push_back(stt_pkg::CharHash);
      end else begin
         text.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // result side: random stall, changed at the falling edge
   always @(negedge clock) begin
      if (stall_hold != 0) stall_hold--;
      else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_hold = pick_wait();
      end
   end

   // result side: check every accepted record
   always @(posedge clock) begin
      stt_pkg::stt_token_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.token_kind  = rsp_token_kind;
         seen.start_pos   = rsp_start_pos;
         seen.token_len   = rsp_token_len;
         seen.line_number = rsp_line_number;
         seen.column      = rsp_column;
         seen.first_char  = rsp_first_char;
         seen.last_of_run = rsp_last_of_run;
         ledger.match_token(seen);
      end
   end

   initial begin
      bit [7:0] text[$];
      int       pieces;
      ledger = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: high bytes, word plus special in one byte, pairs, pending ':' and '=',
      // line and block comments across newlines, escaped quote, lone backslash,
      // newline inside a string, unterminated string flushed at end of text
      text = '{8'h77, 8'hFF, 8'h00, 8'h2E, stt_pkg::CharColon, stt_pkg::CharColon,
               stt_pkg::CharEqual, stt_pkg::CharEqual, stt_pkg::CharColon,
               stt_pkg::CharEqual, stt_pkg::CharHash, 8'h63, stt_pkg::CharNewline,
               stt_pkg::CharHash, stt_pkg::CharHash, stt_pkg::CharNewline,
               stt_pkg::CharHash, stt_pkg::CharHash, stt_pkg::CharDquote,
               stt_pkg::CharBslash, stt_pkg::CharDquote, stt_pkg::CharBslash, 8'h61,
               stt_pkg::CharNewline, stt_pkg::CharDquote, stt_pkg::CharSquote, 8'h7A};
      send_text(text, 1'b1, 1'b0);
      // pending '=' and pending '#' at end of text
      text = '{stt_pkg::CharEqual};
      send_text(text, 1'b1, 1'b0);
      text = '{stt_pkg::CharHash};
      send_text(text, 1'b1, 1'b0);

      // random texts built from well-formed pieces with noise mixed in
      while (sent_bytes < ByteTarget) begin
         text.delete();
         pieces = $urandom_range(1, 30);
         repeat (pieces) add_piece(text);
         send_text(text, $urandom_range(0, 9) != 0, 1'b1);
      end
      req_valid <= 1'b0;

      // drain, then allow late extra records to show up
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.failed) $display("status: fail");
      else $display("status: pass");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_scan.sv
hw/rtl/stt_rsp_fifo.sv
hw/rtl/source_text_tokenizer_top.sv
dv/testbench.sv
